@@ src/ris_pkg.sv @@
// Shared types and constants of the record insertion sorter.
// No dependencies; read by the interfaces, the cell and the top level.
package ris_pkg;

  // Number of records the chain holds
  localparam int unsigned Capacity = 32;
  // Stored bits of the name handle
  localparam int unsigned TagBits  = 8;

  localparam int unsigned IdW    = 32;
  localparam int unsigned GradeW = 9;
  localparam int unsigned TagW   = 8;

  // One stored record
  typedef struct packed {
    logic signed [IdW-1:0] id;
    logic [GradeW-1:0]     grade;
    logic [TagBits-1:0]    tag;
  } rec_t;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic insert;  // new record is loaded this cycle
    logic pop;     // head record leaves, chain shifts towards the head
    rec_t rec;     // record being inserted
  } ris_ctrl_t;

endpackage

@@ src/ris_if.sv @@
// Valid/ready channel interfaces of the record insertion sorter.
// Depend on ris_pkg for the field widths.
interface ris_in_if;
  import ris_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [IdW-1:0] student_id;
  logic [GradeW-1:0]     grade_hundredths;
  logic [TagW-1:0]       record_tag;
  logic                  set_end;

  modport source (output valid, student_id, grade_hundredths, record_tag, set_end,
                  input ready);
  modport sink   (input valid, student_id, grade_hundredths, record_tag, set_end,
                  output ready);
endinterface

interface ris_out_if;
  import ris_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [IdW-1:0] out_id;
  logic [GradeW-1:0]     out_grade;
  logic [TagW-1:0]       out_tag;
  logic                  out_last;
  logic                  overflowed;

  modport source (output valid, out_id, out_grade, out_tag, out_last, overflowed,
                  input ready);
  modport sink   (input valid, out_id, out_grade, out_tag, out_last, overflowed,
                  output ready);
endinterface

@@ src/record_insertion_sorter.sv @@
// Top level of the record insertion sorter: control and the chain of cells.
// Depends on ris_pkg, ris_in_if / ris_out_if and ris_cell.
//
//  channel  | dir | beat carries
//  ---------+-----+-----------------------------------------------------
//  rec_i    | in  | student_id, grade_hundredths, record_tag, set_end
//  rec_o    | out | out_id, out_grade, out_tag, out_last, overflowed
//
// Loading never stalls rec_i: every cell compares the new id at once
// and the slots beyond the insertion point shift one place towards the tail.
// A record carrying set_end is inserted, then the chain drains from its head,
// one beat per cycle while rec_o.ready is high; rec_i is not ready meanwhile.
// A full chain drops the record and flags the run. Reset empties the chain.
module record_insertion_sorter (
  input  logic clk_i,
  input  logic rst_ni,
  ris_in_if.sink    rec_i,
  ris_out_if.source rec_o
);
  import ris_pkg::*;

  typedef enum logic {
    StLoad,
    StDrain
  } state_e;

  state_e    state_q;
  logic      drop_q;
  ris_ctrl_t ctrl;
  logic      in_acc, out_acc, full, run_last;

  logic [Capacity-1:0] ins_w;
  logic [Capacity-1:0] valid_w;
  rec_t                rec_w [Capacity];

  assign full     = valid_w[Capacity-1];
  assign run_last = ~valid_w[1];

  assign rec_i.ready = (state_q == StLoad);
  assign in_acc      = rec_i.valid & rec_i.ready;
  assign rec_o.valid = (state_q == StDrain);
  assign out_acc     = rec_o.valid & rec_o.ready;

  // Broadcast to the cells
  always_comb begin
    ctrl.insert    = in_acc & ~full;
    ctrl.pop       = out_acc;
    ctrl.rec.id    = rec_i.student_id;
    ctrl.rec.grade = rec_i.grade_hundredths;
    ctrl.rec.tag   = rec_i.record_tag[TagBits-1:0];
  end

  // Chain of cells, head at index 0
  for (genvar k = 0; k < Capacity; k++) begin : g_cell
    logic ins_prev, valid_prev, valid_next;
    rec_t rec_prev, rec_next;

    if (k == 0) begin : g_head
      assign ins_prev   = 1'b0;
      assign valid_prev = 1'b0;
      assign rec_prev   = rec_w[0];
    end else begin : g_body
      assign ins_prev   = ins_w[k-1];
      assign valid_prev = valid_w[k-1];
      assign rec_prev   = rec_w[k-1];
    end

    if (k == Capacity-1) begin : g_tail
      assign valid_next = 1'b0;
      assign rec_next   = rec_w[k];
    end else begin : g_inner
      assign valid_next = valid_w[k+1];
      assign rec_next   = rec_w[k+1];
    end

    ris_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .is_head_i    (1'(k == 0)),
      .ctrl_i       (ctrl),
      .ins_prev_i   (ins_prev),
      .valid_prev_i (valid_prev),
      .rec_prev_i   (rec_prev),
      .valid_next_i (valid_next),
      .rec_next_i   (rec_next),
      .ins_o        (ins_w[k]),
      .valid_o      (valid_w[k]),
      .rec_o        (rec_w[k])
    );
  end

  // Output beat straight from the head cell
  assign rec_o.out_id     = rec_w[0].id;
  assign rec_o.out_grade  = rec_w[0].grade;
  assign rec_o.out_tag    = TagW'(rec_w[0].tag);
  assign rec_o.out_last   = run_last;
  assign rec_o.overflowed = drop_q;

  // Load / drain sequencing and the overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      drop_q  <= 1'b0;
    end else begin
      case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (full) drop_q <= 1'b1;
            if (rec_i.set_end) state_q <= StDrain;
          end
        end
        StDrain: begin
          if (out_acc && run_last) begin
            state_q <= StLoad;
            drop_q  <= 1'b0;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // Occupied slots are always packed against the head
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_w >> 1) & ~valid_w) == '0)
    else $error("gap in the chain");

  // A drain never starts on an empty chain
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_o.valid |-> valid_w[0])
    else $error("output beat from an empty head");

  // The last beat leaves the chain empty
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && run_last) |=> (valid_w == '0) && (state_q == StLoad))
    else $error("records left after the last beat");

  // End of set moves to draining
  a_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rec_i.set_end) |=> (state_q == StDrain))
    else $error("end of set did not start the drain");

  // Overflow flag is cleared for the next run
  a_flag_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && run_last) |=> !drop_q)
    else $error("overflow flag carried into the next run");

endmodule

@@ src/ris_cell.sv @@
// One slot of the sorting chain: holds a record and its valid bit.
// Depends on ris_pkg; instantiated Capacity times by record_insertion_sorter.
module ris_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             is_head_i,
  input  ris_pkg::ris_ctrl_t ctrl_i,
  // neighbour towards the head
  input  logic             ins_prev_i,
  input  logic             valid_prev_i,
  input  ris_pkg::rec_t    rec_prev_i,
  // neighbour towards the tail
  input  logic             valid_next_i,
  input  ris_pkg::rec_t    rec_next_i,
  // own state
  output logic             ins_o,
  output logic             valid_o,
  output ris_pkg::rec_t    rec_o
);
  import ris_pkg::*;

  logic valid_q, valid_d;
  rec_t rec_q, rec_d;

  // Slot lies at or beyond the insertion point. The head moves aside only
  // for a strictly smaller id; later slots also for an equal one.
  always_comb begin
    if (!valid_q) begin
      ins_o = 1'b1;
    end else if (is_head_i) begin
      ins_o = ctrl_i.rec.id < rec_q.id;
    end else begin
      ins_o = rec_q.id >= ctrl_i.rec.id;
    end
  end

  // Next content: drain shift, insert, shift towards the tail, or hold
  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (ctrl_i.pop) begin
      valid_d = valid_next_i;
      rec_d   = rec_next_i;
    end else if (ctrl_i.insert && ins_o) begin
      if (!ins_prev_i) begin
        valid_d = 1'b1;
        rec_d   = ctrl_i.rec;
      end else if (valid_prev_i) begin
        valid_d = 1'b1;
        rec_d   = rec_prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload without reset
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule
